>>> sv/frwl_pkg.sv
// Shared types and constants of the reader/writer lock arbiter.
package frwl_pkg;

    localparam int ID_W        = 8;
    localparam int ACT_W       = 2;
    localparam int RES_W       = 2;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int QWORD_W     = ID_W + 1;

    typedef enum logic [ACT_W-1:0] {
        ACT_RD_REQ = 2'd0,
        ACT_WR_REQ = 2'd1,
        ACT_RD_REL = 2'd2,
        ACT_WR_REL = 2'd3
    } action_t;

    typedef enum logic [RES_W-1:0] {
        EV_GRANT  = 2'd0,
        EV_QUEUED = 2'd1,
        EV_NONE   = 2'd2,
        EV_ERROR  = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        event_t          event_res;
        logic [ID_W-1:0] grant_id;
        logic            grant_is_writer;
        logic [7:0]      active_readers_now;
        logic            writer_active_now;
    } result_t;

    // Request from the sequencer to the result stage.
    typedef struct packed {
        logic    push;
        logic    flush;
        result_t res;
    } ostage_cmd_t;

    typedef struct packed {
        logic out_free;
        logic can_push;
    } ostage_sts_t;

endpackage

>>> sv/frwl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module frwl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/frwl_out_stage.sv
// Result staging: one pending result plus the output register of the master side.
module frwl_out_stage
    import frwl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ostage_cmd_t            cmd,
    output ostage_sts_t            sts,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [RES_W-1:0]       m_tuser,
    output logic                   m_tlast
);

    // The pending result is held back until it is known whether more follow.
    logic    pend_valid_reg, pend_valid_next;
    result_t pend_reg, pend_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    last_reg, last_next;
    logic    out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        if (cmd.push)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                last_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = cmd.res;
            pend_valid_next = 1'b1;
        end
        else if (cmd.flush)
        begin
            out_next        = pend_valid_reg ? pend_reg : cmd.res;
            last_next       = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    assign sts.out_free   = out_free;
    assign sts.can_push   = !pend_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tlast  = last_reg;
    assign m_tdata  = {6'd0, out_reg.writer_active_now, out_reg.active_readers_now,
                       out_reg.grant_is_writer, out_reg.grant_id};

endmodule

>>> sv/fifo_reader_writer_lock_arbiter.sv
// Top level of the reader/writer lock arbiter with its wait queue in RAM.
//
// Each input word is one lock event (reader or writer request, reader or writer
// release) from a requester, and it produces one or more result words; the last
// of them carries tlast. Any number of readers, up to MAX_READERS, may hold the
// lock together, or one writer alone. A reader is granted at once unless a writer
// holds the lock, so it can pass waiting writers; a writer is granted only when
// the lock is idle. Requests that cannot be granted wait in a first-in first-out
// queue of QUEUE_DEPTH entries, kept with their kind in a RAM with a registered
// read. A valid release serves the head of the queue: either one writer, or the
// run of readers at the head, with one result word per grant and at most 16
// grants per event. A full queue, a reader beyond the limit or a release with no
// matching holder gives a single error word and changes nothing. A release
// reads every queue entry from the RAM port before it can be tested, and a
// stalled master side holds the block back. The queue is only written while
// the block is idle and only read while it serves a release, so a read never
// meets a write to the same entry. A word is taken only while the block is
// idle.
module fifo_reader_writer_lock_arbiter
    import frwl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_READERS = 255
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // [7:0] requester_id
    input  logic [ACT_W-1:0]       s_tuser,  // [1:0] action
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] grant_id, [8] grant_is_writer, [16:9] active_readers_now,
    // [17] writer_active_now, [23:18] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [RES_W-1:0]       m_tuser,  // [1:0] event_res
    output logic                   m_tlast
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int AR_W = $clog2(MAX_READERS + 1);

    // Low eight bits of the reader count, whatever its width.
    function automatic logic [7:0] low8(input logic [AR_W-1:0] v);
        logic [AR_W+7:0] t;
        t = {8'd0, v};
        return t[7:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [AR_W-1:0]   readers_reg, readers_next;
    logic              writer_reg, writer_next;
    logic [RES_CNT_W-1:0] nres_reg, nres_next;
    logic [ID_W-1:0]   req_id_reg, req_id_next;
    logic              req_wr_reg, req_wr_next;

    ostage_cmd_t       ocmd;
    ostage_sts_t       osts;

    logic              ram_we;
    logic              ram_re;
    logic [QWORD_W-1:0] ram_wdata;
    logic [QWORD_W-1:0] ram_rdata;

    action_t           act;
    logic [ID_W-1:0]   in_id;
    logic              in_wr;
    logic              accept;
    logic              rel_ok;
    logic              is_release;
    logic              head_wr;
    logic [ID_W-1:0]   head_id;
    logic              grant_wr;
    logic              grant_rd;
    logic              queue_stop;
    logic              lock_idle;
    logic              room_for_reader;

    assign act        = action_t'(s_tuser);
    assign in_id      = s_tdata[ID_W-1:0];
    assign in_wr      = (act == ACT_WR_REQ) || (act == ACT_WR_REL);
    assign accept     = s_tvalid && (state_reg == ST_IDLE);
    assign is_release = (act == ACT_RD_REL) || (act == ACT_WR_REL);
    assign rel_ok     = (act == ACT_RD_REL) ? (readers_reg != '0) : writer_reg;

    assign lock_idle       = !writer_reg && (readers_reg == '0);
    assign room_for_reader = readers_reg < AR_W'(MAX_READERS);

    assign head_wr  = ram_rdata[QWORD_W-1];
    assign head_id  = ram_rdata[ID_W-1:0];
    assign grant_wr = head_wr && lock_idle;
    assign grant_rd = !head_wr && !writer_reg && room_for_reader;
    assign queue_stop = (count_reg == '0) || (nres_reg == RES_CNT_W'(MAX_RESULTS));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (is_release && rel_ok) ? ST_READ : ST_FINISH;
                end
            end
            ST_READ:
            begin
                state_next = queue_stop ? ST_FINISH : ST_CHECK;
            end
            ST_CHECK:
            begin
                if (grant_wr && osts.can_push)
                begin
                    state_next = ST_FINISH;
                end
                else if (grant_rd && osts.can_push)
                begin
                    state_next = ST_READ;
                end
                else if (!grant_wr && !grant_rd)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (osts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, queue access and result requests.
    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        readers_next = readers_reg;
        writer_next  = writer_reg;
        nres_next    = nres_reg;
        req_id_next  = req_id_reg;
        req_wr_next  = req_wr_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_wdata    = {in_wr, in_id};
        s_tready     = 1'b0;
        ocmd         = '0;
        ocmd.res.event_res       = EV_ERROR;
        ocmd.res.grant_id        = in_id;
        ocmd.res.grant_is_writer = in_wr;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    req_id_next = in_id;
                    req_wr_next = in_wr;
                    nres_next   = '0;
                    ocmd.push   = !(is_release && rel_ok);
                    unique case (act)
                        ACT_RD_REQ:
                        begin
                            if (!writer_reg && room_for_reader)
                            begin
                                readers_next       = readers_reg + 1'b1;
                                ocmd.res.event_res = EV_GRANT;
                            end
                            else if (writer_reg && (count_reg != QCNT_W'(QUEUE_DEPTH)))
                            begin
                                ram_we             = 1'b1;
                                tail_next          = ptr_inc(tail_reg);
                                count_next         = count_reg + 1'b1;
                                ocmd.res.event_res = EV_QUEUED;
                            end
                        end
                        ACT_WR_REQ:
                        begin
                            if (lock_idle)
                            begin
                                writer_next        = 1'b1;
                                ocmd.res.event_res = EV_GRANT;
                            end
                            else if (count_reg != QCNT_W'(QUEUE_DEPTH))
                            begin
                                ram_we             = 1'b1;
                                tail_next          = ptr_inc(tail_reg);
                                count_next         = count_reg + 1'b1;
                                ocmd.res.event_res = EV_QUEUED;
                            end
                        end
                        ACT_RD_REL:
                        begin
                            if (rel_ok)
                            begin
                                readers_next = readers_reg - 1'b1;
                            end
                        end
                        ACT_WR_REL:
                        begin
                            if (rel_ok)
                            begin
                                writer_next = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                ram_re = !queue_stop;
            end
            ST_CHECK:
            begin
                ocmd.res.event_res       = EV_GRANT;
                ocmd.res.grant_id        = head_id;
                ocmd.res.grant_is_writer = head_wr;
                if ((grant_wr || grant_rd) && osts.can_push)
                begin
                    ocmd.push  = 1'b1;
                    head_next  = ptr_inc(head_reg);
                    count_next = count_reg - 1'b1;
                    nres_next  = nres_reg + 1'b1;
                    if (grant_wr)
                    begin
                        writer_next = 1'b1;
                    end
                    else
                    begin
                        readers_next = readers_reg + 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                // With nothing pending the release granted no one.
                ocmd.flush               = osts.out_free;
                ocmd.res.event_res       = EV_NONE;
                ocmd.res.grant_id        = req_id_reg;
                ocmd.res.grant_is_writer = req_wr_reg;
            end
            default:
            begin
            end
        endcase

        ocmd.res.active_readers_now = low8(readers_next);
        ocmd.res.writer_active_now  = writer_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            readers_reg <= '0;
            writer_reg  <= 1'b0;
            nres_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            readers_reg <= readers_next;
            writer_reg  <= writer_next;
            nres_reg    <= nres_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_id_reg <= req_id_next;
        req_wr_reg <= req_wr_next;
    end

    frwl_ram #(
        .WIDTH (QWORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    frwl_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (ocmd),
        .sts      (osts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> sv/frwl_checker.sv
// Port-level checks of the lock arbiter and their binding to the top level.
module frwl_checker
    import frwl_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic [ACT_W-1:0]       s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [RES_W-1:0]       m_tuser,
    input logic                   m_tlast
);

    // A stalled result word holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    // Only one input word is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while busy");

    // A writer never holds the lock alongside readers.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[17] && (m_tdata[16:9] != 8'd0)))
        else $error("writer and readers active together");

    // A writer grant leaves the writer flag set.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == EV_GRANT) && m_tdata[8] |-> m_tdata[17])
        else $error("writer granted without writer flag");

    // Queued, error and empty-release words always close their event.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != EV_GRANT) |-> m_tlast)
        else $error("non-grant word not marked last");

endmodule

bind fifo_reader_writer_lock_arbiter frwl_checker u_frwl_checker (.*);

>>> tb/frwl_grant_checker.sv
// Checker that predicts the arbiter's result words and compares them as they leave.
`timescale 1ns / 1ps

module frwl_grant_checker
    import frwl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [ACT_W-1:0]       s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic [RES_W-1:0]       m_tuser,
    input  logic                   m_tlast,
    output int                     mismatches,
    output int                     words_due
);

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_READERS = 255;

    typedef struct packed {
        event_t          ev;
        logic [ID_W-1:0] id;
        logic            wr;
        logic [7:0]      readers;
        logic            writer;
        logic            last;
    } lock_word_t;

    lock_word_t      due_grants[$];
    lock_word_t      batch[$];

    logic [ID_W-1:0] wait_ids[QUEUE_DEPTH];
    logic            wait_wr[QUEUE_DEPTH];
    int              wait_head;
    int              wait_count;
    int              readers_held;
    logic            writer_held;

    task automatic record(input event_t ev, input logic [ID_W-1:0] id, input logic wr);
        lock_word_t w;
        w.ev      = ev;
        w.id      = id;
        w.wr      = wr;
        w.readers = 8'(readers_held);
        w.writer  = writer_held;
        w.last    = 1'b0;
        batch.push_back(w);
    endtask

    task automatic queue_request(input logic [ID_W-1:0] id, input logic wr);
        int slot;
        if (wait_count >= QUEUE_DEPTH)
        begin
            record(EV_ERROR, id, wr);
        end
        else
        begin
            slot = (wait_head + wait_count) % QUEUE_DEPTH;
            wait_ids[slot] = id;
            wait_wr[slot]  = wr;
            wait_count++;
            record(EV_QUEUED, id, wr);
        end
    endtask

    // Hand the lock to the head of the queue: one writer, or the run of readers.
    task automatic hand_over();
        int h;
        while (wait_count > 0 && batch.size() < MAX_RESULTS)
        begin
            h = wait_head;
            if (wait_wr[h])
            begin
                if (!writer_held && readers_held == 0)
                begin
                    wait_head = (wait_head + 1) % QUEUE_DEPTH;
                    wait_count--;
                    writer_held = 1'b1;
                    record(EV_GRANT, wait_ids[h], 1'b1);
                end
                break;
            end
            if (writer_held || readers_held >= MAX_READERS)
                break;
            wait_head = (wait_head + 1) % QUEUE_DEPTH;
            wait_count--;
            readers_held++;
            record(EV_GRANT, wait_ids[h], 1'b0);
        end
    endtask

    task automatic apply_lock_event(input action_t act, input logic [ID_W-1:0] id);
        case (act)
            ACT_RD_REQ:
            begin
                if (writer_held)
                begin
                    queue_request(id, 1'b0);
                end
                else if (readers_held < MAX_READERS)
                begin
                    readers_held++;
                    record(EV_GRANT, id, 1'b0);
                end
                else
                begin
                    record(EV_ERROR, id, 1'b0);
                end
            end
            ACT_WR_REQ:
            begin
                if (!writer_held && readers_held == 0)
                begin
                    writer_held = 1'b1;
                    record(EV_GRANT, id, 1'b1);
                end
                else
                begin
                    queue_request(id, 1'b1);
                end
            end
            ACT_RD_REL:
            begin
                if (readers_held == 0)
                begin
                    record(EV_ERROR, id, 1'b0);
                end
                else
                begin
                    readers_held--;
                    hand_over();
                    if (batch.size() == 0)
                        record(EV_NONE, id, 1'b0);
                end
            end
            default:
            begin
                if (!writer_held)
                begin
                    record(EV_ERROR, id, 1'b1);
                end
                else
                begin
                    writer_held = 1'b0;
                    hand_over();
                    if (batch.size() == 0)
                        record(EV_NONE, id, 1'b1);
                end
            end
        endcase
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            due_grants.push_back(batch[i]);
        batch.delete();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lock_word_t got;
        lock_word_t want;
        if (!rst_n)
        begin
            due_grants.delete();
            batch.delete();
            wait_head    = 0;
            wait_count   = 0;
            readers_held = 0;
            writer_held  = 1'b0;
            mismatches   = 0;
            words_due    = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_lock_event(action_t'(s_tuser), s_tdata[ID_W-1:0]);

            if (m_tvalid && m_tready)
            begin
                got.ev      = event_t'(m_tuser);
                got.id      = m_tdata[7:0];
                got.wr      = m_tdata[8];
                got.readers = m_tdata[16:9];
                got.writer  = m_tdata[17];
                got.last    = m_tlast;
                if (due_grants.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with nothing outstanding: res=%0d id=%02h",
                                 $time, got.ev, got.id);
                end
                else
                begin
                    want = due_grants.pop_front();
                    if (got !== want || m_tdata[23:18] !== 6'd0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: result word mismatch: expected res=%0d id=%02h ",
                                      "wr=%0d readers=%0d writer=%0d last=%0d, got res=%0d ",
                                      "id=%02h wr=%0d readers=%0d writer=%0d last=%0d pad=%02h"},
                                     $time, want.ev, want.id, want.wr, want.readers,
                                     want.writer, want.last, got.ev, got.id, got.wr,
                                     got.readers, got.writer, got.last, m_tdata[23:18]);
                    end
                end
            end
            words_due = due_grants.size();
        end
    end

endmodule

>>> tb/tb.sv
// Top of the testbench: drives lock events into the arbiter and gives the verdict.
`timescale 1ns / 1ps

module tb;
    import frwl_pkg::*;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [7:0] requester_id
    logic [ACT_W-1:0]       s_tuser  = ACT_RD_REQ;   // [1:0] action
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [7:0] id, [8] writer, [16:9] readers, [17] writer active
    logic [RES_W-1:0]       m_tuser;   // [1:0] event_res
    logic                   m_tlast;

    int mismatches;
    int words_due;

    // Burst flags switch idling off for a stretch of words on either side.
    logic tx_burst = 1'b0;
    logic rx_burst = 1'b0;
    int   words_taken = 0;

    always #1 clk = ~clk;

    fifo_reader_writer_lock_arbiter uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    frwl_grant_checker grant_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .words_due  (words_due)
    );

    // Offer one lock event and hold it until the arbiter takes the word. A random
    // gap goes before it, except during a burst. s_tvalid gets only one assignment
    // per edge: it is lowered only when a gap follows.
    task automatic offer_word(input action_t act, input logic [7:0] id);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= id;
        s_tuser  <= act;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
    endtask

    // Receiver: a random pause before each result word, and once, early on, a
    // long hold-off so that the arbiter backs up and refuses new words.
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 15);
            if (words_taken == 40)
                gap = 400;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            words_taken++;
        end
    end

    initial
    begin
        int          mode;
        int unsigned pick;
        int unsigned w_rd_req;
        int unsigned w_wr_req;
        int unsigned w_rd_rel;
        action_t     act;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Releases with nobody holding the lock are refused first.
        offer_word(ACT_RD_REL, 8'h00);
        offer_word(ACT_WR_REL, 8'hFF);
        // A reader takes the lock; a writer must then wait, and a later reader
        // passes the waiting writer.
        offer_word(ACT_RD_REQ, 8'h00);
        offer_word(ACT_WR_REQ, 8'hFF);
        offer_word(ACT_RD_REQ, 8'h80);
        // The first release leaves one reader, so nothing is handed over; the
        // second one empties the lock and the waiting writer gets it.
        offer_word(ACT_RD_REL, 8'h5A);
        offer_word(ACT_RD_REL, 8'h7E);
        // With the writer holding, sixteen readers fill the queue, and two more
        // requests find it full.
        for (int k = 1; k <= 16; k++)
            offer_word(ACT_RD_REQ, 8'(k * 17));
        offer_word(ACT_RD_REQ, 8'hA5);
        offer_word(ACT_WR_REQ, 8'h3C);
        // The writer release hands the lock to the whole run of sixteen readers.
        offer_word(ACT_WR_REL, 8'hC3);
        offer_word(ACT_RD_REL, 8'h69);

        // Random part, in segments that lean towards contention, towards
        // draining the lock, or neither, so that the queue fills and empties.
        for (int seg = 0; seg < 10; seg++)
        begin
            mode = $urandom_range(0, 2);
            case (mode)
                0:
                begin
                    w_rd_req = 35;
                    w_wr_req = 55;
                    w_rd_rel = 80;
                end
                1:
                begin
                    w_rd_req = 35;
                    w_wr_req = 65;
                    w_rd_rel = 80;
                end
                default:
                begin
                    w_rd_req = 15;
                    w_wr_req = 25;
                    w_rd_rel = 65;
                end
            endcase
            for (int k = 0; k < 13; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < w_rd_req)
                    act = ACT_RD_REQ;
                else if (pick < w_wr_req)
                    act = ACT_WR_REQ;
                else if (pick < w_rd_rel)
                    act = ACT_RD_REL;
                else
                    act = ACT_WR_REL;
                offer_word(act, 8'($urandom_range(0, 255)));
            end
        end

        // Reader limit. Seventeen writer releases are enough to leave no writer
        // holding whatever the queue held, since each one can hand over to at
        // most one waiting writer. After that every reader request is granted
        // until the limit is reached, and the last few are refused. A writer
        // request now and then lands in the queue or finds it full.
        for (int k = 0; k < 17; k++)
            offer_word(ACT_WR_REL, 8'($urandom_range(0, 255)));
        for (int k = 0; k < 262; k++)
            offer_word((k % 64 == 63) ? ACT_WR_REQ : ACT_RD_REQ,
                       8'($urandom_range(0, 255)));
        s_tvalid <= 1'b0;

        // Let every expected result word drain, then leave a margin for any
        // stray word before the verdict.
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (mismatches == 0 && words_due == 0)
            $display("[fifo_reader_writer_lock_arbiter] OK");
        else
            $display("[fifo_reader_writer_lock_arbiter] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("[fifo_reader_writer_lock_arbiter] ERROR");
        $finish;
    end

endmodule
